FILE: sv/admd_pkg.sv
// Shared types and constants for the adaptive differential motor drive.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package admd_pkg;

  // Field widths
  localparam int TGT_W   = 13;  // speed targets and measurements, signed
  localparam int SUM_W   = 14;  // sums and differences of two speeds
  localparam int MS_W    = 16;
  localparam int GAIN_W  = 16;
  localparam int SCALE_W = 31;  // Q7.24 scale factors, unsigned
  localparam int RPS_W   = 16;
  localparam int RAW_W   = 15;
  localparam int DRV_W   = 16;
  localparam int IDX_W   = 3;

  // Lane datapath widths
  localparam int PROD_W  = 64;
  localparam int SPEED_W = 30;  // speed, Q.7
  localparam int WSPD_W  = 37;  // wheel-scaled speed, Q.7
  localparam int ULO_W   = 18;  // low slice of the wheel-scaled speed
  localparam int PLO_W   = 34;
  localparam int RAWS_W  = 36;

  localparam logic [SCALE_W-1:0] SCALE_ONE      = 31'd16777216;
  localparam logic [13:0]        DIFF_THRESHOLD = 14'd5;

  // Rounding offsets for the three shifts of the drive path
  localparam logic signed [47:0] HALF_SPEED = 48'sd65536;
  localparam logic signed [63:0] HALF_WHEEL = 64'sd8388608;
  localparam logic signed [55:0] HALF_RAW   = 56'sd524288;

  // Register indexes of the configuration port
  localparam logic [IDX_W-1:0] REG_SCALE_GAIN    = 3'd0;
  localparam logic [IDX_W-1:0] REG_DIFF_GAIN     = 3'd1;
  localparam logic [IDX_W-1:0] REG_SCALE_MIN     = 3'd2;
  localparam logic [IDX_W-1:0] REG_SCALE_MAX     = 3'd3;
  localparam logic [IDX_W-1:0] REG_DIFF_MIN      = 3'd4;
  localparam logic [IDX_W-1:0] REG_DIFF_MAX      = 3'd5;
  localparam logic [IDX_W-1:0] REG_RAW_PER_SPEED = 3'd6;
  localparam logic [IDX_W-1:0] REG_MAX_RAW       = 3'd7;

  // Register reset values
  localparam logic [GAIN_W-1:0]  RST_SCALE_GAIN    = 16'd64;
  localparam logic [GAIN_W-1:0]  RST_DIFF_GAIN     = 16'd4096;
  localparam logic [SCALE_W-1:0] RST_SCALE_MIN     = 31'd8388608;
  localparam logic [SCALE_W-1:0] RST_SCALE_MAX     = 31'd33554432;
  localparam logic [SCALE_W-1:0] RST_DIFF_MIN      = 31'd16777216;
  localparam logic [SCALE_W-1:0] RST_DIFF_MAX      = 31'd67108864;
  localparam logic [RPS_W-1:0]   RST_RAW_PER_SPEED = 16'd4096;
  localparam logic [RAW_W-1:0]   RST_MAX_RAW       = 15'd400;

  // Sequencer steps, one per cycle of a tick; ST_OUT holds while the result is stalled
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,     // gain * speed error
    ST_DELTA,   // * elapsed time; differential scale update
    ST_SCALE,   // wheel scale update; differential term product
    ST_SPEED,   // round to speed, Q.7
    ST_WHEEL,   // speed * wheel scale
    ST_ROUND,   // round to wheel-scaled speed
    ST_RLO,     // low partial product with raw_per_speed
    ST_RHI,     // high partial product with raw_per_speed
    ST_CLAMP,   // round to raw units and clamp
    ST_OUT      // merge lanes, load result register
  } admd_state_t;

  typedef struct packed {
    admd_state_t step;
    logic        learn;
  } admd_ctl_t;

endpackage

`default_nettype wire

FILE: sv/admd_diff.sv
// Differential scale learning unit: holds the differential scale factor.
// Depends on admd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module admd_diff (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire admd_pkg::admd_ctl_t              ctl,
  input  wire logic signed [admd_pkg::TGT_W-1:0] prev_left,
  input  wire logic signed [admd_pkg::TGT_W-1:0] prev_right,
  input  wire logic signed [admd_pkg::TGT_W-1:0] left_meas,
  input  wire logic signed [admd_pkg::TGT_W-1:0] right_meas,
  input  wire logic [admd_pkg::GAIN_W-1:0]       diff_gain,
  input  wire logic [admd_pkg::SCALE_W-1:0]      diff_min,
  input  wire logic [admd_pkg::SCALE_W-1:0]      diff_max,
  output logic [admd_pkg::SCALE_W-1:0]           diff_scale
);
  import admd_pkg::*;

  logic signed [SUM_W-1:0] dt, adt, dm;
  logic signed [15:0]      term;
  logic signed [32:0]      pd;
  logic signed [33:0]      sum_v;
  logic                    big;

  always_comb begin
    dt    = SUM_W'(prev_right) - SUM_W'(prev_left);
    adt   = (dt < 0) ? -dt : dt;
    dm    = SUM_W'(right_meas) - SUM_W'(left_meas);
    term  = (dt > 0) ? (16'(adt) - 16'(dm)) : (16'(adt) + 16'(dm));
    big   = (adt >= $signed(DIFF_THRESHOLD));
    sum_v = 34'($signed({1'b0, diff_scale})) + 34'(pd);
  end

  always_ff @(posedge clk) begin
    if (ctl.step == ST_ERR) begin
      pd <= 33'($signed({1'b0, diff_gain}) * term);
    end
  end

  // Upper limit first, then lower; min wins only at or below max
  always_ff @(posedge clk) begin
    if (rst) begin
      diff_scale <= SCALE_ONE;
    end else if (ctl.step == ST_DELTA && ctl.learn && big) begin
      if (sum_v > $signed({3'b0, diff_max})) begin
        diff_scale <= diff_max;
      end else if (sum_v < $signed({3'b0, diff_min})) begin
        diff_scale <= diff_min;
      end else begin
        diff_scale <= sum_v[SCALE_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/admd_lane.sv
// One wheel lane: learns the wheel scale and forms the raw drive command
// with a single shared multiplier stepped by the sequencer. Depends on admd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module admd_lane (
  input  wire                                    clk,
  input  wire                                    rst,
  input  wire admd_pkg::admd_ctl_t               ctl,
  input  wire logic signed [admd_pkg::TGT_W-1:0] prev_target,
  input  wire logic signed [admd_pkg::TGT_W-1:0] measured,
  input  wire logic [admd_pkg::MS_W-1:0]         elapsed,
  input  wire logic signed [admd_pkg::SUM_W-1:0] speed_sum,
  input  wire logic signed [admd_pkg::SUM_W-1:0] speed_diff,
  input  wire logic [admd_pkg::SCALE_W-1:0]      diff_scale,
  input  wire logic [admd_pkg::GAIN_W-1:0]       scale_gain,
  input  wire logic [admd_pkg::SCALE_W-1:0]      scale_min,
  input  wire logic [admd_pkg::SCALE_W-1:0]      scale_max,
  input  wire logic [admd_pkg::RPS_W-1:0]        raw_per_speed,
  input  wire logic [admd_pkg::RAW_W-1:0]        max_raw,
  output logic [admd_pkg::SCALE_W-1:0]           scale,
  output logic signed [admd_pkg::DRV_W-1:0]      drive,
  output logic                                   sat
);
  import admd_pkg::*;

  logic signed [SUM_W-1:0]  err;
  logic signed [31:0]       mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p, prod;
  logic signed [SPEED_W-1:0] spd;
  logic signed [WSPD_W-1:0] wspd;
  logic [PLO_W-1:0]         plo;
  logic signed [48:0]       sc_v;
  logic signed [47:0]       s2;
  logic signed [PROD_W-1:0] wr;
  logic signed [55:0]       rs;
  logic signed [RAWS_W-1:0] raw, lim;

  assign err = SUM_W'(prev_target) - SUM_W'(measured);

  // Operand select for the shared multiplier
  always_comb begin
    case (ctl.step)
      ST_ERR: begin
        mul_a = 32'($signed({1'b0, scale_gain}));
        mul_b = 32'(err);
      end
      ST_DELTA: begin
        mul_a = prod[31:0];
        mul_b = 32'($signed({1'b0, elapsed}));
      end
      ST_SCALE: begin
        mul_a = 32'($signed({1'b0, diff_scale}));
        mul_b = 32'(speed_diff);
      end
      ST_WHEEL: begin
        mul_a = 32'($signed({1'b0, scale}));
        mul_b = 32'(spd);
      end
      ST_RLO: begin
        mul_a = 32'($signed({1'b0, wspd[ULO_W-1:0]}));
        mul_b = 32'($signed({1'b0, raw_per_speed}));
      end
      ST_RHI: begin
        mul_a = 32'($signed(wspd[WSPD_W-1:ULO_W]));
        mul_b = 32'($signed({1'b0, raw_per_speed}));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    sc_v = 49'($signed({1'b0, scale})) + prod[48:0];
    s2   = (48'(speed_sum) <<< 24) + prod[47:0] + HALF_SPEED;
    wr   = prod + HALF_WHEEL;
    rs   = (56'($signed(prod[35:0])) <<< ULO_W) + 56'(plo) + HALF_RAW;
    raw  = rs[55:20];
    lim  = RAWS_W'(max_raw);
  end

  always_ff @(posedge clk) begin
    case (ctl.step)
      ST_ERR, ST_DELTA, ST_SCALE, ST_WHEEL, ST_RLO, ST_RHI: begin
        prod <= mul_p;
      end
      default: begin
        prod <= prod;
      end
    endcase
    if (ctl.step == ST_SPEED) begin
      spd <= s2[46:17];
    end
    if (ctl.step == ST_ROUND) begin
      wspd <= wr[60:24];
    end
    if (ctl.step == ST_RHI) begin
      plo <= prod[PLO_W-1:0];
    end
    if (ctl.step == ST_CLAMP) begin
      if (raw > lim) begin
        drive <= DRV_W'(max_raw);
        sat   <= 1'b1;
      end else if (raw < -lim) begin
        drive <= -DRV_W'(max_raw);
        sat   <= 1'b1;
      end else begin
        drive <= raw[DRV_W-1:0];
        sat   <= 1'b0;
      end
    end
  end

  // Upper limit first, then lower
  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= SCALE_ONE;
    end else if (ctl.step == ST_SCALE && ctl.learn) begin
      if (sc_v > $signed({18'b0, scale_max})) begin
        scale <= scale_max;
      end else if (sc_v < $signed({18'b0, scale_min})) begin
        scale <= scale_min;
      end else begin
        scale <= sc_v[SCALE_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/adaptive_differential_motor_drive.sv
// Top level: configuration registers, tick sequencer, two wheel lanes,
// differential unit and the merging result register. Depends on admd_pkg,
// admd_lane and admd_diff.
//
//   channel  signals                       moves
//   -------  ----------------------------  -------------------------------
//   s_       s_tvalid s_tready s_tdata     control tick request in
//            s_tuser
//   m_       m_tvalid m_tready m_tdata     drive commands and scales out
//            m_tuser
//   cfg_     cfg_valid cfg_ready           register write
//            cfg_index cfg_data
//
// A tick runs from acceptance to a valid result in nine steps of the
// lanes' shared multiplier and adders, then the merge into the result
// register. The sequencer returns to idle as the result loads, and only
// then takes the next request. A result waiting on m_tready does not hold
// off the next request; a stalled result holds the block in its merge step.
// rst is synchronous and restores the register defaults and all scales to 1.0.
// cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none

module adaptive_differential_motor_drive (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  s_tvalid,
  output logic                                 s_tready,
  // left_target[12:0] right_target[25:13] left_measured[38:26]
  // right_measured[51:39] elapsed_ms[67:52] zero[71:68]
  input  wire logic [71:0]                     s_tdata,
  // stop_request[0]
  input  wire logic                            s_tuser,
  output logic                                 m_tvalid,
  input  wire                                  m_tready,
  // left_drive[15:0] right_drive[31:16] left_scale_now[62:32]
  // right_scale_now[93:63] diff_scale_now[124:94] zero[127:125]
  output logic [127:0]                         m_tdata,
  // drive_saturated[0]
  output logic                                 m_tuser,
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [admd_pkg::IDX_W-1:0]      cfg_index,
  input  wire logic [admd_pkg::SCALE_W-1:0]    cfg_data
);
  import admd_pkg::*;

  // Configuration
  logic [GAIN_W-1:0]  scale_gain, diff_gain;
  logic [SCALE_W-1:0] scale_min, scale_max, diff_min, diff_max;
  logic [RPS_W-1:0]   raw_per_speed;
  logic [RAW_W-1:0]   max_raw;

  // Tick state
  admd_state_t state, state_next;
  admd_ctl_t   ctl;
  logic signed [TGT_W-1:0] lt, rt, lm, rm;
  logic [MS_W-1:0]         el;
  logic                    learn;
  logic signed [TGT_W-1:0] prev_left, prev_right;
  logic                    prev_sat, have_prev;
  logic signed [SUM_W-1:0] spd_sum, diff_l, diff_r;

  logic [SCALE_W-1:0]      l_scale, r_scale, d_scale;
  logic signed [DRV_W-1:0] l_drive, r_drive;
  logic                    l_sat, r_sat, tick_sat;
  logic                    s_acc, out_load;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign s_acc     = s_tvalid && s_tready;
  assign out_load  = (state == ST_OUT) && (!m_tvalid || m_tready);
  assign tick_sat  = l_sat | r_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_gain    <= RST_SCALE_GAIN;
      diff_gain     <= RST_DIFF_GAIN;
      scale_min     <= RST_SCALE_MIN;
      scale_max     <= RST_SCALE_MAX;
      diff_min      <= RST_DIFF_MIN;
      diff_max      <= RST_DIFF_MAX;
      raw_per_speed <= RST_RAW_PER_SPEED;
      max_raw       <= RST_MAX_RAW;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SCALE_GAIN:    scale_gain    <= cfg_data[GAIN_W-1:0];
        REG_DIFF_GAIN:     diff_gain     <= cfg_data[GAIN_W-1:0];
        REG_SCALE_MIN:     scale_min     <= cfg_data;
        REG_SCALE_MAX:     scale_max     <= cfg_data;
        REG_DIFF_MIN:      diff_min      <= cfg_data;
        REG_DIFF_MAX:      diff_max      <= cfg_data;
        REG_RAW_PER_SPEED: raw_per_speed <= cfg_data[RPS_W-1:0];
        REG_MAX_RAW:       max_raw       <= cfg_data[RAW_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the request; a stop zeroes both targets
  always_ff @(posedge clk) begin
    if (s_acc) begin
      lt    <= s_tuser ? '0 : $signed(s_tdata[12:0]);
      rt    <= s_tuser ? '0 : $signed(s_tdata[25:13]);
      lm    <= $signed(s_tdata[38:26]);
      rm    <= $signed(s_tdata[51:39]);
      el    <= s_tdata[67:52];
      learn <= have_prev && !prev_sat &&
               ((prev_left > 0 && prev_right > 0) ||
                (prev_left < 0 && prev_right < 0));
    end
  end

  assign spd_sum = SUM_W'(lt) + SUM_W'(rt);
  assign diff_l  = SUM_W'(lt) - SUM_W'(rt);
  assign diff_r  = SUM_W'(rt) - SUM_W'(lt);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    case (state)
      ST_IDLE:  state_next = s_acc ? ST_ERR : ST_IDLE;
      ST_ERR:   state_next = ST_DELTA;
      ST_DELTA: state_next = ST_SCALE;
      ST_SCALE: state_next = ST_SPEED;
      ST_SPEED: state_next = ST_WHEEL;
      ST_WHEEL: state_next = ST_ROUND;
      ST_ROUND: state_next = ST_RLO;
      ST_RLO:   state_next = ST_RHI;
      ST_RHI:   state_next = ST_CLAMP;
      ST_CLAMP: state_next = ST_OUT;
      ST_OUT:   state_next = out_load ? ST_IDLE : ST_OUT;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl.step  = state;
    ctl.learn = learn;
  end

  admd_lane u_lane_left (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .prev_target   (prev_left),
    .measured      (lm),
    .elapsed       (el),
    .speed_sum     (spd_sum),
    .speed_diff    (diff_l),
    .diff_scale    (d_scale),
    .scale_gain    (scale_gain),
    .scale_min     (scale_min),
    .scale_max     (scale_max),
    .raw_per_speed (raw_per_speed),
    .max_raw       (max_raw),
    .scale         (l_scale),
    .drive         (l_drive),
    .sat           (l_sat)
  );

  admd_lane u_lane_right (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .prev_target   (prev_right),
    .measured      (rm),
    .elapsed       (el),
    .speed_sum     (spd_sum),
    .speed_diff    (diff_r),
    .diff_scale    (d_scale),
    .scale_gain    (scale_gain),
    .scale_min     (scale_min),
    .scale_max     (scale_max),
    .raw_per_speed (raw_per_speed),
    .max_raw       (max_raw),
    .scale         (r_scale),
    .drive         (r_drive),
    .sat           (r_sat)
  );

  admd_diff u_diff (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .prev_left  (prev_left),
    .prev_right (prev_right),
    .left_meas  (lm),
    .right_meas (rm),
    .diff_gain  (diff_gain),
    .diff_min   (diff_min),
    .diff_max   (diff_max),
    .diff_scale (d_scale)
  );

  // Merge the lanes: advance the history and load the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_left  <= '0;
      prev_right <= '0;
      prev_sat   <= 1'b0;
      have_prev  <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (out_load) begin
        prev_left  <= lt;
        prev_right <= rt;
        prev_sat   <= tick_sat;
        have_prev  <= 1'b1;
        m_tvalid   <= 1'b1;
      end else if (m_tready) begin
        m_tvalid   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {3'b0, d_scale, r_scale, l_scale, r_drive, l_drive};
      m_tuser <= tick_sat;
    end
  end

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for adaptive_differential_motor_drive: a directed tick table, then
// randomised ticks over several register settings, each result checked by a local predictor.
// Depends on admd_pkg and the block's RTL; needs no files or arguments.
module tb_top;
  import admd_pkg::*;

  typedef struct packed {
    logic signed [TGT_W-1:0] lt;
    logic signed [TGT_W-1:0] rt;
    logic signed [TGT_W-1:0] lm;
    logic signed [TGT_W-1:0] rm;
    logic [MS_W-1:0]         el;
    logic                    stop;
  } tick_t;

  typedef struct packed {
    logic signed [DRV_W-1:0] left_drive;
    logic signed [DRV_W-1:0] right_drive;
    logic                    sat;
    logic [SCALE_W-1:0]      left_scale;
    logic [SCALE_W-1:0]      right_scale;
    logic [SCALE_W-1:0]      diff_scale;
  } drive_result_t;

  // Directed tick; the typed drives are checked only where known is set
  typedef struct packed {
    logic signed [TGT_W-1:0] lt;
    logic signed [TGT_W-1:0] rt;
    logic signed [TGT_W-1:0] lm;
    logic signed [TGT_W-1:0] rm;
    logic [MS_W-1:0]         el;
    logic                    stop;
    logic                    known;
    logic signed [DRV_W-1:0] ld;
    logic signed [DRV_W-1:0] rd;
    logic                    sat;
  } plan_row_t;

  plan_row_t plan [18] = '{
    //  lt     rt     lm     rm     el  stop known  ld    rd  sat
    '{  100,   -50,     0,     0,     0, 0, 1,  100,  -50, 0},
    '{ 4095, -4096,  4095, -4096, 65535, 1, 1,    0,    0, 0},
    '{ 4095,  4095,     0,     0,   100, 0, 1,  400,  400, 1},
    '{-4096, -4096,     0,     0,   100, 0, 1, -400, -400, 1},
    '{  200,   300,     0,     0,     0, 0, 1,  200,  300, 0},
    '{ -300,  -200,   190,   310,    10, 0, 0,    0,    0, 0},
    '{ -300,  -298, -4096,  4095, 65535, 0, 0,    0,    0, 0},
    '{ 1000,  1000,     0,     0,     1, 0, 0,    0,    0, 0},
    '{   40,    44,    40,    44,    20, 0, 0,    0,    0, 0},
    '{   40,    44,    35,    50,    20, 0, 0,    0,    0, 0},
    '{   50,    45,    60,    30,    30, 0, 0,    0,    0, 0},
    '{  -10,    -5,     0,     0,     5, 0, 0,    0,    0, 0},
    '{   -1,    -1, -4096, -4096,     0, 0, 0,    0,    0, 0},
    '{    0,     7,     0,     0,     3, 1, 0,    0,    0, 0},
    '{    0,     7,     1,     1,     3, 0, 0,    0,    0, 0},
    '{    7,     0,    -1,    -1,     3, 0, 0,    0,    0, 0},
    '{-4096,  4095,  4095, -4096, 65535, 0, 0,    0,    0, 0},
    '{    1,     1, -4096,  4095, 65535, 0, 0,    0,    0, 0}
  };

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [71:0]          s_tdata = '0;
  logic                 s_tuser = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [127:0]         m_tdata;
  logic                 m_tuser;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [IDX_W-1:0]     cfg_index = '0;
  logic [SCALE_W-1:0]   cfg_data = '0;

  drive_result_t        pending_drives [$];
  logic [SCALE_W-1:0]   next_regs [8];
  int                   mismatches = 0;
  int                   results_seen = 0;
  bit                   no_gaps = 1'b0;

  // Predictor state and register copies
  longint l_scale, r_scale, d_scale, last_l, last_r;
  bit     last_clamped, seen_tick;
  longint rate_wheel, rate_diff, wheel_lo, wheel_hi, diff_lo, diff_hi, raw_gain, raw_limit;

  adaptive_differential_motor_drive i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void reset_predictor();
    rate_wheel   = 64;
    rate_diff    = 4096;
    wheel_lo     = 8388608;
    wheel_hi     = 33554432;
    diff_lo      = 16777216;
    diff_hi      = 67108864;
    raw_gain     = 4096;
    raw_limit    = 400;
    l_scale      = 16777216;
    r_scale      = 16777216;
    d_scale      = 16777216;
    last_l       = 0;
    last_r       = 0;
    last_clamped = 1'b0;
    seen_tick    = 1'b0;
  endfunction

  function automatic void apply_reg(logic [IDX_W-1:0] idx, logic [SCALE_W-1:0] data);
    case (idx)
      REG_SCALE_GAIN:    rate_wheel = longint'(data[15:0]);
      REG_DIFF_GAIN:     rate_diff  = longint'(data[15:0]);
      REG_SCALE_MIN:     wheel_lo   = longint'(data);
      REG_SCALE_MAX:     wheel_hi   = longint'(data);
      REG_DIFF_MIN:      diff_lo    = longint'(data);
      REG_DIFF_MAX:      diff_hi    = longint'(data);
      REG_RAW_PER_SPEED: raw_gain   = longint'(data[15:0]);
      REG_MAX_RAW:       raw_limit  = longint'(data[14:0]);
      default: ;
    endcase
  endfunction

  // Divide by 2^n, rounding to nearest with ties upward
  function automatic longint round_q(longint v, int n);
    return (v + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  // Upper bound tested first, so with an inverted pair a value above hi lands on hi, any other on lo
  function automatic longint limit(longint v, longint lo, longint hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic longint wheel_command(longint sum, longint dif, longint wheel,
                                           inout bit clipped);
    longint speed2, speed, scaled, raw;
    speed2 = sum * longint'(SCALE_ONE) + d_scale * dif;
    speed  = round_q(speed2, 17);
    scaled = round_q(speed * wheel, 24);
    raw    = round_q(scaled * raw_gain, 20);
    if (raw > raw_limit) begin
      clipped = 1'b1;
      return raw_limit;
    end
    if (raw < -raw_limit) begin
      clipped = 1'b1;
      return -raw_limit;
    end
    return raw;
  endfunction

  function automatic drive_result_t predict_drive(tick_t t);
    longint lt, rt, lm, rm, el, dt, adt, dm, ld, rd;
    bit clipped;
    drive_result_t r;
    lt = t.stop ? 0 : longint'($signed(t.lt));
    rt = t.stop ? 0 : longint'($signed(t.rt));
    lm = longint'($signed(t.lm));
    rm = longint'($signed(t.rm));
    el = longint'(t.el);
    clipped = 1'b0;
    // learn only from an unsaturated previous tick whose targets share a sign
    if (seen_tick && !last_clamped &&
        ((last_l > 0 && last_r > 0) || (last_l < 0 && last_r < 0))) begin
      l_scale = limit(l_scale + rate_wheel * (last_l - lm) * el, wheel_lo, wheel_hi);
      r_scale = limit(r_scale + rate_wheel * (last_r - rm) * el, wheel_lo, wheel_hi);
      dt  = last_r - last_l;
      adt = dt < 0 ? -dt : dt;
      if (adt >= longint'(DIFF_THRESHOLD)) begin
        dm = rm - lm;
        d_scale = limit(d_scale + rate_diff * (dt > 0 ? adt - dm : adt + dm),
                        diff_lo, diff_hi);
      end
    end
    ld = wheel_command(lt + rt, lt - rt, l_scale, clipped);
    rd = wheel_command(lt + rt, rt - lt, r_scale, clipped);
    last_clamped = clipped;
    last_l       = lt;
    last_r       = rt;
    seen_tick    = 1'b1;
    r.left_drive  = DRV_W'(ld);
    r.right_drive = DRV_W'(rd);
    r.sat         = clipped;
    r.left_scale  = SCALE_W'(l_scale);
    r.right_scale = SCALE_W'(r_scale);
    r.diff_scale  = SCALE_W'(d_scale);
    return r;
  endfunction

  function automatic tick_t random_tick();
    tick_t t;
    int sgn, cap, lt, rt;
    if ($urandom_range(0, 9) < 2) begin
      // noise: every field at full width
      t.lt   = TGT_W'($urandom);
      t.rt   = TGT_W'($urandom);
      t.lm   = TGT_W'($urandom);
      t.rm   = TGT_W'($urandom);
      t.el   = MS_W'($urandom);
      t.stop = 1'($urandom);
    end else begin
      // well-formed drive: targets of one sign or within four of each other, measurements near them
      sgn = $urandom_range(0, 1) ? 1 : -1;
      cap = $urandom_range(0, 3) == 0 ? 4095 : 500;
      lt  = sgn * int'($urandom_range(1, cap));
      rt  = $urandom_range(0, 3) == 0 ? lt + int'($urandom_range(0, 8)) - 4
                                      : sgn * int'($urandom_range(1, cap));
      t.lt   = TGT_W'(limit(longint'(lt), -4096, 4095));
      t.rt   = TGT_W'(limit(longint'(rt), -4096, 4095));
      t.lm   = TGT_W'(limit(longint'(lt + int'($urandom_range(0, 80)) - 40), -4096, 4095));
      t.rm   = TGT_W'(limit(longint'(rt + int'($urandom_range(0, 80)) - 40), -4096, 4095));
      t.el   = $urandom_range(0, 7) == 0 ? MS_W'($urandom) : MS_W'($urandom_range(0, 100));
      t.stop = ($urandom_range(0, 19) == 0);
    end
    return t;
  endfunction

  task automatic report(input string msg);
    $display("[%0t] %s", $time, msg);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input longint got, input longint want);
    if (got != want)
      report($sformatf("result %0d %s: got %0d, expected %0d", results_seen, name, got, want));
  endtask

  task automatic send_tick(input tick_t t);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata  <= {4'b0, t.el, t.rm, t.lm, t.rt, t.lt};
    s_tuser  <= t.stop;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  // Write all eight registers back to back, holding valid across them
  task automatic program_regs();
    for (int i = 0; i < 8; i++) begin
      cfg_index <= IDX_W'(i);
      cfg_data  <= next_regs[IDX_W'(i)];
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
      apply_reg(IDX_W'(i), next_regs[IDX_W'(i)]);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic check_result(input logic [127:0] data, input logic user);
    drive_result_t want;
    results_seen++;
    if (pending_drives.size() == 0) begin
      report($sformatf("result %0d arrived with no tick outstanding", results_seen));
      return;
    end
    want = pending_drives.pop_front();
    compare_field("left_drive", longint'($signed(data[15:0])),
                  longint'($signed(want.left_drive)));
    compare_field("right_drive", longint'($signed(data[31:16])),
                  longint'($signed(want.right_drive)));
    compare_field("drive_saturated", longint'(user), longint'(want.sat));
    compare_field("left_scale_now", longint'(data[62:32]), longint'(want.left_scale));
    compare_field("right_scale_now", longint'(data[93:63]), longint'(want.right_scale));
    compare_field("diff_scale_now", longint'(data[124:94]), longint'(want.diff_scale));
  endtask

  // Result side: random stall before each result unless no_gaps is set, then wait for it
  initial begin
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      check_result(m_tdata, m_tuser);
    end
  end

  initial begin
    tick_t t;
    drive_result_t r;
    reset_predictor();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      t = '{plan[i].lt, plan[i].rt, plan[i].lm, plan[i].rm, plan[i].el, plan[i].stop};
      send_tick(t);
      r = predict_drive(t);
      if (plan[i].known) begin
        r.left_drive  = plan[i].ld;
        r.right_drive = plan[i].rd;
        r.sat         = plan[i].sat;
        r.left_scale  = SCALE_ONE;
        r.right_scale = SCALE_ONE;
        r.diff_scale  = SCALE_ONE;
      end
      pending_drives.push_back(r);
    end

    for (int phase = 1; phase <= 8; phase++) begin
      // drop valid and drain before touching the registers
      s_tvalid <= 1'b0;
      while (pending_drives.size() != 0) @(posedge clk);
      case (phase)
        1: begin
          // inverted limits: a learned scale above its maximum lands on the maximum, any other on the minimum
          next_regs[REG_SCALE_GAIN]    = 31'd65535;
          next_regs[REG_DIFF_GAIN]     = 31'd65535;
          next_regs[REG_SCALE_MIN]     = 31'h7FFF_FFFF;
          next_regs[REG_SCALE_MAX]     = '0;
          next_regs[REG_DIFF_MIN]      = 31'h7FFF_FFFF;
          next_regs[REG_DIFF_MAX]      = '0;
          next_regs[REG_RAW_PER_SPEED] = 31'd65535;
          next_regs[REG_MAX_RAW]       = 31'd32767;
        end
        2: begin
          next_regs[REG_SCALE_GAIN]    = '0;
          next_regs[REG_DIFF_GAIN]     = '0;
          next_regs[REG_SCALE_MIN]     = '0;
          next_regs[REG_SCALE_MAX]     = 31'h7FFF_FFFF;
          next_regs[REG_DIFF_MIN]      = '0;
          next_regs[REG_DIFF_MAX]      = 31'h7FFF_FFFF;
          next_regs[REG_RAW_PER_SPEED] = '0;
          next_regs[REG_MAX_RAW]       = '0;
        end
        default: begin
          next_regs[REG_SCALE_GAIN] = $urandom_range(0, 3) == 0 ?
              SCALE_W'($urandom_range(0, 65535)) : SCALE_W'($urandom_range(0, 400));
          next_regs[REG_DIFF_GAIN] = $urandom_range(0, 3) == 0 ?
              SCALE_W'($urandom_range(0, 65535)) : SCALE_W'($urandom_range(0, 16384));
          next_regs[REG_SCALE_MIN] = SCALE_W'($urandom_range(0, 1 << 24));
          next_regs[REG_SCALE_MAX] = SCALE_W'($urandom_range(1 << 23, 1 << 27));
          next_regs[REG_DIFF_MIN]  = SCALE_W'($urandom_range(0, 1 << 25));
          next_regs[REG_DIFF_MAX]  = SCALE_W'($urandom_range(1 << 24, 1 << 28));
          next_regs[REG_RAW_PER_SPEED] = $urandom_range(0, 3) == 0 ?
              SCALE_W'($urandom_range(0, 65535)) : SCALE_W'($urandom_range(1024, 12288));
          next_regs[REG_MAX_RAW] = $urandom_range(0, 3) == 0 ?
              SCALE_W'($urandom_range(0, 32767)) : SCALE_W'($urandom_range(50, 2000));
          // unused upper bits of the narrow registers must be ignored
          if ($urandom_range(0, 1)) begin
            next_regs[REG_SCALE_GAIN]    |= SCALE_W'($urandom) & 31'h7FFF_0000;
            next_regs[REG_DIFF_GAIN]     |= SCALE_W'($urandom) & 31'h7FFF_0000;
            next_regs[REG_RAW_PER_SPEED] |= SCALE_W'($urandom) & 31'h7FFF_0000;
            next_regs[REG_MAX_RAW]       |= SCALE_W'($urandom) & 31'h7FFF_8000;
          end
        end
      endcase
      program_regs();
      no_gaps = (phase % 3 == 0);
      repeat (75) begin
        t = random_tick();
        send_tick(t);
        pending_drives.push_back(predict_drive(t));
      end
    end

    s_tvalid <= 1'b0;
    while (pending_drives.size() != 0) @(posedge clk);
    // catch any stray result after the last expected one
    repeat (30) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
